// ----- hdl/cob_pkg.sv -----
// Shared types and constants for the cursor overlay alpha blend core.
`timescale 1ns / 1ps

package cob_pkg;

    // Sprite memory geometry.
    localparam int SPRITE_DEPTH = 1024;
    localparam int SPRITE_AW    = 10;

    // Default cursor geometry.
    localparam int CURSOR_SIZE_DEF = 32;
    localparam int HOTSPOT_DEF     = 2;

    // Field widths.
    localparam int COORD_W = 12;
    localparam int FRAME_W = 13;
    localparam int PIXEL_W = 32;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 13;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_POINTER_X    = 2'd2;
    localparam logic [CFG_IW-1:0] REG_POINTER_Y    = 2'd3;

    // Request types.
    localparam logic REQ_COMPOSE = 1'b0;
    localparam logic REQ_WRITE   = 1'b1;

    // A pixel after the sprite lookup, on its way to the blend stages.
    typedef struct packed {
        logic               hit;
        logic [PIXEL_W-1:0] bg;
        logic [PIXEL_W-1:0] src;
    } cob_pix_t;

endpackage

// ----- hdl/cursor_overlay_alpha_blend_core.sv -----
// Top level of the hardware cursor overlay: registers, sprite memory and lookup stage.
//
//   channel   direction  handshake            payload
//   s_*       in         s_valid / s_ready    request type, pixel, background, sprite word
//   m_*       out        m_valid / m_ready    composed pixel, covered flag
//   cfg_*     in         cfg_wen              register index, write data
//
// One beat is taken per cycle while s_ready is high; a compose beat reaches m_* through
// the registers at the sprite memory read, the channel products, and the divide and
// output register.
// A sprite write beat updates the memory at its accept edge and produces no output.
// Reset clears the configuration registers and the pipeline valids; the sprite memory is not cleared.
// While m_ready is low the three stages keep filling; s_ready drops only when all are full.
`timescale 1ns / 1ps

module cursor_overlay_alpha_blend_core #(
    parameter int CURSOR_SIZE = cob_pkg::CURSOR_SIZE_DEF,
    parameter int HOTSPOT     = cob_pkg::HOTSPOT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [cob_pkg::COORD_W-1:0]     s_pixel_x,
    input  logic [cob_pkg::COORD_W-1:0]     s_pixel_y,
    input  logic [cob_pkg::PIXEL_W-1:0]     s_background_pixel,
    input  logic [cob_pkg::SPRITE_AW-1:0]   s_sprite_index,
    input  logic [cob_pkg::PIXEL_W-1:0]     s_sprite_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cob_pkg::PIXEL_W-1:0]     m_composed_pixel,
    output logic                            m_covered,
    input  logic                            cfg_wen,
    input  logic [cob_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [cob_pkg::CFG_DW-1:0]      cfg_wdata
);
    import cob_pkg::*;

    localparam int CW = (CURSOR_SIZE > 1) ? $clog2(CURSOR_SIZE) : 1;
    localparam int PW = (2 * CW > SPRITE_AW) ? 2 * CW : SPRITE_AW;
    localparam int DW = COORD_W + 2;

    logic [FRAME_W-1:0] frame_width_reg, frame_height_reg;
    logic [COORD_W-1:0] pointer_x_reg, pointer_y_reg;

    logic [PIXEL_W-1:0] sprite_mem [SPRITE_DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    logic               s1_v_reg, s1_v_next;
    logic               s1_hit_reg, s1_hit_next;
    logic [PIXEL_W-1:0] s1_bg_reg;

    logic               en1, accept, blend_ready;
    logic [DW-1:0]      dx, dy;
    logic [PW-1:0]      addr_full;
    logic [SPRITE_AW-1:0] rd_addr;
    cob_pix_t           s1_pix;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            pointer_x_reg    <= '0;
            pointer_y_reg    <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                REG_POINTER_X:    pointer_x_reg    <= cfg_wdata[COORD_W-1:0];
                REG_POINTER_Y:    pointer_y_reg    <= cfg_wdata[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign en1     = !s1_v_reg || blend_ready;
    assign s_ready = en1;
    assign accept  = s_valid && en1;

    // Offset from the cursor origin; the origin may lie left of or above the frame.
    assign dx = {2'b00, s_pixel_x} - {2'b00, pointer_x_reg} + DW'(HOTSPOT);
    assign dy = {2'b00, s_pixel_y} - {2'b00, pointer_y_reg} + DW'(HOTSPOT);

    assign s1_hit_next = ({1'b0, s_pixel_x} < frame_width_reg)
                      && ({1'b0, s_pixel_y} < frame_height_reg)
                      && !dx[DW-1] && (dx < DW'(CURSOR_SIZE))
                      && !dy[DW-1] && (dy < DW'(CURSOR_SIZE));

    assign addr_full = PW'(dy[CW-1:0]) * PW'(CURSOR_SIZE) + PW'(dx[CW-1:0]);
    assign rd_addr   = addr_full[SPRITE_AW-1:0];

    assign s1_v_next = accept && (s_req_type == REQ_COMPOSE);

    // Sprite memory: one write port, one registered read port. A write lands at its
    // accept edge, so any later compose reads the new word.
    always_ff @(posedge aclk) begin
        if (accept && (s_req_type == REQ_WRITE)) begin
            sprite_mem[s_sprite_index] <= s_sprite_word;
        end
        if (en1) begin
            rd_data_reg <= sprite_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en1) begin
            s1_v_reg <= s1_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_hit_reg <= s1_hit_next;
            s1_bg_reg  <= s_background_pixel;
        end
    end

    assign s1_pix.hit = s1_hit_reg;
    assign s1_pix.bg  = s1_bg_reg;
    assign s1_pix.src = rd_data_reg;

    cob_blend u_blend (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s1_v_reg),
        .in_ready         (blend_ready),
        .in_pix           (s1_pix),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_composed_pixel (m_composed_pixel),
        .m_covered        (m_covered)
    );

endmodule

// ----- hdl/cob_blend.sv -----
// Alpha blend datapath: channel products, divide by 255 and the output register.
`timescale 1ns / 1ps

module cob_blend (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  cob_pkg::cob_pix_t       in_pix,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [cob_pkg::PIXEL_W-1:0] m_composed_pixel,
    output logic                    m_covered
);
    import cob_pkg::*;

    // Exact x / 255 for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] y;
        logic [16:0] q;
        y = 17'(x) + 17'd1;
        q = (y + (y >> 8)) >> 8;
        return q[7:0];
    endfunction

    logic        s2_v_reg, s2_v_next;
    logic        s2_cov_reg;
    logic        s2_opaque_reg;
    logic [PIXEL_W-1:0] s2_bg_reg;
    logic [23:0] s2_src_reg;
    logic [15:0] s2_sum_reg [3];
    logic [15:0] sum_next [3];

    logic        m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0] m_pixel_reg, m_pixel_next;
    logic        m_cov_reg;

    logic        en2, en3;
    logic [7:0]  alpha, inv_alpha;
    logic        in_cov, in_opaque;

    assign en3      = !m_valid_reg || m_ready;
    assign en2      = !s2_v_reg || en3;
    assign in_ready = en2;

    assign alpha     = in_pix.src[31:24];
    assign inv_alpha = 8'd255 - alpha;
    assign in_cov    = in_pix.hit && (alpha != 8'd0);
    assign in_opaque = (alpha == 8'd255);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum_next[c] = 16'(in_pix.bg[c*8 +: 8] * inv_alpha)
                        + 16'(in_pix.src[c*8 +: 8] * alpha);
        end
    end

    assign s2_v_next    = in_valid;
    assign m_valid_next = s2_v_reg;

    always_comb begin
        if (!s2_cov_reg) begin
            m_pixel_next = s2_bg_reg;
        end else if (s2_opaque_reg) begin
            m_pixel_next = {8'h00, s2_src_reg};
        end else begin
            m_pixel_next = {8'h00, div255(s2_sum_reg[2]), div255(s2_sum_reg[1]),
                            div255(s2_sum_reg[0])};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en2) begin
                s2_v_reg <= s2_v_next;
            end
            if (en3) begin
                m_valid_reg <= m_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && in_valid) begin
            s2_cov_reg    <= in_cov;
            s2_opaque_reg <= in_opaque;
            s2_bg_reg     <= in_pix.bg;
            s2_src_reg    <= in_pix.src[23:0];
            for (int c = 0; c < 3; c++) begin
                s2_sum_reg[c] <= sum_next[c];
            end
        end
        if (en3 && s2_v_reg) begin
            m_pixel_reg <= m_pixel_next;
            m_cov_reg   <= s2_cov_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_composed_pixel = m_pixel_reg;
    assign m_covered        = m_cov_reg;

endmodule
